FILE: sv/ukt_pkg.sv
// Shared types and constants for the unique key table.
// No dependencies; imported by ukt_cell and unique_key_table_unit.
`default_nettype none

package ukt_pkg;

   localparam int KEY_W            = 31;
   localparam int KIND_W           = 2;
   localparam int STATUS_W         = 3;
   localparam int INDEX_W          = 7;
   localparam int OCC_W            = 8;
   localparam int DEFAULT_CAPACITY = 128;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_UPDATE = 2'd3
   } ukt_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_PRESENT    = 3'd1,
      ST_ABSENT     = 3'd2,
      ST_FULL       = 3'd3,
      ST_NEW_EXISTS = 3'd4
   } ukt_status_type;

endpackage

`default_nettype wire

FILE: sv/ukt_cell.sv
// One slot of the rotating key ring.
// Depends on ukt_pkg for the key width.
`default_nettype none

module ukt_cell
   import ukt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             shift_en,
   input  wire logic [KEY_W-1:0] shift_in,
   output logic      [KEY_W-1:0] key_out
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;

   // take the neighbor's key while the ring advances, hold otherwise
   assign key_in  = shift_en ? shift_in : key_ff;
   assign key_out = key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

FILE: sv/unique_key_table_unit.sv
// Top level of the unique key table: handshake, sequencer and the cell ring.
// Depends on ukt_pkg and ukt_cell.
`default_nettype none

// The table holds up to CAPACITY unique 31-bit keys packed into slots
// 0 .. occupancy-1, kept in a ring of CAPACITY cells that rotates one slot
// per cycle toward cell 0 while it scans or rewrites. One operation is in
// flight at a time. After a request transfer the ring makes one full turn
// while cell 0 is compared with the key and the new key, then the sequencer
// passes through a decision state. Add, delete and update that succeed take
// a second full turn in which the tail cell is loaded with the added or
// replaced key, or, for delete, with the key two cells ahead so every later
// slot moves down by one. A result then waits in a done state until the
// output register is free, and is registered there. A finished response is
// held in an output register, so the next request is taken while it waits.
// Status codes: 0 ok, 1 already present, 2 not found, 3 table full, 4 new
// key exists; index is 0 unless status is ok.

module unique_key_table_unit
   import ukt_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // key [30:0], new_key [61:31], zero [63:62]
   input  wire logic [1:0]  req_tuser,   // kind [1:0]

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // status [2:0], index [9:3], occupancy [17:10]
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MODIFY,
      S_DONE
   } state_type;

   // sequencer registers
   state_type        state_ff,     state_in;
   logic [IDX_W-1:0] step_ff,      step_in;
   logic [CNT_W-1:0] cnt_ff,       cnt_in;
   ukt_kind_type     kind_ff,      kind_in;
   logic [KEY_W-1:0] key_ff,       key_in;
   logic [KEY_W-1:0] nkey_ff,      nkey_in;
   logic             found_ff,     found_in;
   logic             nk_found_ff,  nk_found_in;
   logic [IDX_W-1:0] slot_ff,      slot_in;
   logic [IDX_W-1:0] tgt_ff,       tgt_in;
   ukt_status_type   res_stat_ff,  res_stat_in;
   logic [IDX_W-1:0] res_idx_ff,   res_idx_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   ukt_status_type   rsp_stat_ff,  rsp_stat_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [OCC_W-1:0] rsp_occ_ff,   rsp_occ_in;

   // ring
   logic [KEY_W-1:0] cell_key [CAPACITY];
   logic [KEY_W-1:0] tail_in;
   logic             shift_en;
   logic [KEY_W-1:0] head_key;
   logic             head_live;
   logic             last_step;

   // width adapters for the fixed-width response fields
   logic [IDX_W+INDEX_W-1:0] idx_ext;
   logic [CNT_W+OCC_W-1:0]   occ_ext;

   assign head_key  = cell_key[0];
   assign head_live = CNT_W'(step_ff) < cnt_ff;
   assign last_step = step_ff == IDX_W'(CAPACITY - 1);
   assign shift_en  = (state_ff == S_SCAN) || (state_ff == S_MODIFY);

   assign idx_ext = {{INDEX_W{1'b0}}, res_idx_ff};
   assign occ_ext = {{OCC_W{1'b0}}, cnt_ff};

   // tail input: rotate unchanged during the scan; during the rewrite turn
   // load the new key at the target slot, or close the gap on delete
   always_comb begin
      tail_in = head_key;
      if (state_ff == S_MODIFY) begin
         unique case (kind_ff)
            KIND_ADD: begin
               if (step_ff == tgt_ff) tail_in = key_ff;
            end
            KIND_UPDATE: begin
               if (step_ff == tgt_ff) tail_in = nkey_ff;
            end
            KIND_DELETE: begin
               if (step_ff >= tgt_ff) tail_in = cell_key[1];
            end
            KIND_SEARCH: begin
               tail_in = head_key;
            end
            default: tail_in = head_key;
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] nbr;
      if (i == CAPACITY - 1) begin : g_tail
         assign nbr = tail_in;
      end else begin : g_body
         assign nbr = cell_key[i+1];
      end
      ukt_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .shift_in (nbr),
         .key_out  (cell_key[i])
      );
   end

   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      nkey_in      = nkey_ff;
      found_in     = found_ff;
      nk_found_in  = nk_found_ff;
      slot_in      = slot_ff;
      tgt_in       = tgt_ff;
      res_stat_in  = res_stat_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_occ_in   = rsp_occ_ff;

      // drop the response once it has been transferred
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in     = ukt_kind_type'(req_tuser);
               key_in      = req_tdata[KEY_W-1:0];
               nkey_in     = req_tdata[2*KEY_W-1:KEY_W];
               found_in    = 1'b0;
               nk_found_in = 1'b0;
               slot_in     = '0;
               step_in     = '0;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            // first match of the key gives the slot; any match of new key counts
            if (head_live && !found_ff && head_key == key_ff) begin
               found_in = 1'b1;
               slot_in  = step_ff;
            end
            if (head_live && head_key == nkey_ff) nk_found_in = 1'b1;
            step_in = step_ff + 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            res_stat_in = ST_OK;
            res_idx_in  = '0;
            tgt_in      = slot_ff;
            state_in    = S_DONE;
            unique case (kind_ff)
               KIND_ADD: begin
                  if (found_ff) begin
                     res_stat_in = ST_PRESENT;
                  end else if (cnt_ff == CNT_W'(CAPACITY)) begin
                     res_stat_in = ST_FULL;
                  end else begin
                     tgt_in     = IDX_W'(cnt_ff);
                     res_idx_in = IDX_W'(cnt_ff);
                     cnt_in     = cnt_ff + 1'b1;
                     state_in   = S_MODIFY;
                  end
               end
               KIND_DELETE: begin
                  if (!found_ff) begin
                     res_stat_in = ST_ABSENT;
                  end else begin
                     res_idx_in = slot_ff;
                     cnt_in     = cnt_ff - 1'b1;
                     state_in   = S_MODIFY;
                  end
               end
               KIND_SEARCH: begin
                  if (!found_ff) res_stat_in = ST_ABSENT;
                  else           res_idx_in  = slot_ff;
               end
               KIND_UPDATE: begin
                  if (!found_ff) begin
                     res_stat_in = ST_ABSENT;
                  end else if (nk_found_ff) begin
                     res_stat_in = ST_NEW_EXISTS;
                  end else begin
                     res_idx_in = slot_ff;
                     state_in   = S_MODIFY;
                  end
               end
               default: res_stat_in = ST_OK;
            endcase
         end

         S_MODIFY: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_idx_in   = idx_ext[INDEX_W-1:0];
               rsp_occ_in   = occ_ext[OCC_W-1:0];
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      nkey_ff     <= nkey_in;
      found_ff    <= found_in;
      nk_found_ff <= nk_found_in;
      slot_ff     <= slot_in;
      tgt_ff      <= tgt_in;
      res_stat_ff <= res_stat_in;
      res_idx_ff  <= res_idx_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_occ_ff, rsp_idx_ff, rsp_stat_ff};

   // occupancy never passes the table size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a request transfer always starts a fresh scan from slot zero
   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SCAN && step_ff == '0))
      else $error("scan did not start after request");

   // the step counter rests at zero outside the two ring turns
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      !shift_en |-> step_ff == '0)
      else $error("step counter moved outside a ring turn");

   // count only changes in the decision cycle
   a_cnt_change: assert property (@(posedge clock) disable iff (reset)
      (cnt_in != cnt_ff) |-> state_ff == S_DECIDE)
      else $error("entry count changed outside decision");

endmodule

`default_nettype wire
